>>> design/jac_pkg.sv
package jac_pkg;

    localparam int CFG_W      = 15;
    localparam int SMALL_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_W      = 16;
    localparam int OUT_LIMIT  = 20000;
    localparam int HELD_RESET = 200;
    localparam int VW         = 18;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = CFG_W;
    localparam int DIV_CYCLES = 16;
    localparam int DIV_CNT_W  = 4;

    localparam logic [CFG_W-1:0] RANGE_LOW_RESET    = 15'd0;
    localparam logic [CFG_W-1:0] RANGE_CENTER_RESET = 15'd10000;
    localparam logic [CFG_W-1:0] RANGE_HIGH_RESET   = 15'd20000;

    typedef logic signed [VW-1:0] t_sval;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW    = 3'd0,
        CFG_RANGE_CENTER = 3'd1,
        CFG_RANGE_HIGH   = 3'd2,
        CFG_DEAD_ZONE    = 3'd3,
        CFG_JITTER_UP    = 3'd4,
        CFG_JITTER_DOWN  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]   range_low;
        logic [CFG_W-1:0]   range_center;
        logic [CFG_W-1:0]   range_high;
        logic [SMALL_W-1:0] dead_zone;
        logic [SMALL_W-1:0] jitter_up;
        logic [SMALL_W-1:0] jitter_down;
    } t_cfg;

    typedef struct packed {
        logic [DIVISOR_W-1:0]  rem;
        logic [DIVIDEND_W-1:0] q;
    } t_div_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HYST,
        ST_CLAMP,
        ST_SIDE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

>>> design/jac_in_if.sv
interface jac_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_position;

    modport source (output valid, output raw_position, input ready);
    modport sink   (input valid, input raw_position, output ready);
endinterface

>>> design/jac_out_if.sv
interface jac_out_if ();
    logic                                valid;
    logic                                ready;
    logic signed [jac_pkg::OUT_W-1:0]    calibrated_position;

    modport source (output valid, output calibrated_position, input ready);
    modport sink   (input valid, input calibrated_position, output ready);
endinterface

>>> design/jac_cfg_regs.sv
module jac_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [jac_pkg::CFG_W-1:0]      i_data,
    output jac_pkg::t_cfg                  o_cfg
);
    import jac_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_low    <= RANGE_LOW_RESET;
            r_cfg.range_center <= RANGE_CENTER_RESET;
            r_cfg.range_high   <= RANGE_HIGH_RESET;
            r_cfg.dead_zone    <= '0;
            r_cfg.jitter_up    <= '0;
            r_cfg.jitter_down  <= '0;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_index))
                CFG_RANGE_LOW:    r_cfg.range_low    <= i_data;
                CFG_RANGE_CENTER: r_cfg.range_center <= i_data;
                CFG_RANGE_HIGH:   r_cfg.range_high   <= i_data;
                CFG_DEAD_ZONE:    r_cfg.dead_zone    <= i_data[SMALL_W-1:0];
                CFG_JITTER_UP:    r_cfg.jitter_up    <= i_data[SMALL_W-1:0];
                CFG_JITTER_DOWN:  r_cfg.jitter_down  <= i_data[SMALL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/jac_divider.sv
module jac_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [jac_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  logic [jac_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic [jac_pkg::DIVIDEND_W-1:0]   o_quotient,
    output logic                             o_done
);
    import jac_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVISOR_W-1:0]  r_div;
    t_div_state            r_st;
    t_div_state            n_st1;
    t_div_state            n_st2;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_div_state div_step(t_div_state s, logic [DIVISOR_W-1:0] d);
        logic [DIVISOR_W:0] t;
        t_div_state         n;
        t   = {s.rem, s.q[DIVIDEND_W-1]};
        n.q = {s.q[DIVIDEND_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            t      = t - {1'b0, d};
            n.q[0] = 1'b1;
        end
        n.rem = t[DIVISOR_W-1:0];
        return n;
    endfunction

    always_comb begin
        n_st1 = div_step(r_st, r_div);
        n_st2 = div_step(n_st1, r_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_st.rem <= '0;
            r_st.q   <= i_dividend;
            r_div    <= i_divisor;
        end else if (r_busy) begin
            r_st <= n_st2;
        end
    end

    assign o_quotient = r_st.q;
    assign o_done     = r_done;

endmodule

>>> design/joystick_axis_calibrator.sv
// channel    dir   payload                       beat taken when
// i_sample   in    raw_position, SAMPLE_BITS u   valid && ready
// o_result   out   calibrated_position, 16 s     valid && ready
//
// one sample at a time, ready only in idle; then HYST, CLAMP, SIDE, MUL, DIV, OUT
// cost set by the 2-bit-per-cycle restoring divider over a 32-bit dividend
// back to idle once the result beat is taken
// synchronous active-low reset: limits to defaults, held position to 200
// a stalled result holds the block; config writes taken at any time
module joystick_axis_calibrator #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jac_pkg::CFG_W-1:0]      i_cfg_data,
    jac_in_if.sink                         i_sample,
    jac_out_if.source                      o_result
);
    import jac_pkg::*;

    localparam int HW = SAMPLE_BITS + 2;
    localparam int CW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;

    t_cfg cfg;

    t_state r_state;
    t_state n_state;

    logic in_ready;
    logic out_valid;
    logic div_start;
    logic div_done;
    logic [DIVIDEND_W-1:0] div_q;

    logic [SAMPLE_BITS-1:0] in_raw;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_held;

    logic                 r_zero;
    logic [CFG_W-1:0]     r_pos_c;
    t_sval                r_el;
    t_sval                r_eh;
    t_sval                r_w1;
    t_sval                r_w2;

    logic [OUT_W-1:0]     r_mag_r;
    logic [OUT_W-1:0]     r_mag_w;
    logic [DIVISOR_W-1:0] r_divisor;
    logic                 r_neg;
    logic signed [OUT_W-1:0] r_result;

    jac_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_sample.valid) n_state = ST_HYST;
            ST_HYST:  n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_SIDE;
            ST_SIDE:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_OUT;
            ST_OUT:   if (o_result.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (r_state == ST_IDLE);
        out_valid = (r_state == ST_OUT);
        div_start = (r_state == ST_MUL);
    end

    assign in_raw                       = i_sample.raw_position;
    assign i_sample.ready               = in_ready;
    assign o_result.valid               = out_valid;
    assign o_result.calibrated_position = r_result;

    // anti-jitter against held position
    logic signed [HW-1:0] h_a;
    logic signed [HW-1:0] h_held;
    logic signed [HW-1:0] h_up;
    logic signed [HW-1:0] h_dn;
    logic                 h_take;

    always_comb begin
        h_a    = $signed({2'b00, r_sample});
        h_held = $signed({2'b00, r_held});
        h_up   = h_held + $signed(HW'(cfg.jitter_up));
        h_dn   = h_held - $signed(HW'(cfg.jitter_down));
        if (h_a > h_held) begin
            h_take = (h_a > h_up);
        end else begin
            h_take = (h_a < h_dn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= SAMPLE_BITS'(HELD_RESET);
        end else if (r_state == ST_HYST && h_take) begin
            r_held <= r_sample;
        end
    end

    // dead zone and clamp
    logic signed [CW-1:0] c_a;
    logic signed [CW-1:0] c_lo;
    logic signed [CW-1:0] c_hi;
    logic signed [CW-1:0] c_ctr;
    logic signed [CW-1:0] c_dz;
    logic signed [CW-1:0] c_el;
    logic signed [CW-1:0] c_eh;
    logic signed [CW-1:0] c_cl;
    logic signed [CW-1:0] c_w1;
    logic signed [CW-1:0] c_w2;
    logic                 c_zero;

    always_comb begin
        c_a    = $signed(CW'(r_held));
        c_lo   = $signed(CW'(cfg.range_low));
        c_hi   = $signed(CW'(cfg.range_high));
        c_ctr  = $signed(CW'(cfg.range_center));
        c_dz   = $signed(CW'(cfg.dead_zone));
        c_el   = c_ctr - c_dz;
        c_eh   = c_ctr + c_dz;
        c_zero = (c_a >= c_el) && (c_a <= c_eh);
        priority if (c_a < c_lo) begin
            c_cl = c_lo;
        end else if (c_a > c_hi) begin
            c_cl = c_hi;
        end else begin
            c_cl = c_a;
        end
        c_w1 = c_el - c_lo;
        c_w2 = c_hi - c_eh;
    end

    // side selection and magnitudes for the multiply
    t_sval s_pc;
    t_sval s_rr;
    t_sval s_rabs;
    t_sval s_num;
    t_sval s_nabs;
    t_sval s_den;
    logic  s_below;
    logic  s_scale;

    always_comb begin
        s_pc    = $signed({3'b000, r_pos_c});
        s_below = (r_pos_c < cfg.range_center);
        if (s_below) begin
            s_rr    = s_pc - r_el;
            s_scale = (r_w1 > r_w2);
            s_num   = r_w2;
            s_den   = r_w1;
        end else begin
            s_rr    = s_pc - r_eh;
            s_scale = (r_w2 > r_w1);
            s_num   = r_w1;
            s_den   = r_w2;
        end
        s_rabs = s_rr[VW-1] ? -s_rr : s_rr;
        s_nabs = s_num[VW-1] ? -s_num : s_num;
    end

    // saturate and sign the quotient
    logic [OUT_W-1:0]        d_mag;
    logic signed [OUT_W-1:0] d_res;

    always_comb begin
        if (div_q > DIVIDEND_W'(OUT_LIMIT)) begin
            d_mag = OUT_W'(OUT_LIMIT);
        end else begin
            d_mag = div_q[OUT_W-1:0];
        end
        d_res = r_neg ? $signed(~d_mag + OUT_W'(1)) : $signed(d_mag);
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_sample.valid) begin
            r_sample <= in_raw;
        end
        if (r_state == ST_CLAMP) begin
            r_zero  <= c_zero;
            r_pos_c <= c_cl[CFG_W-1:0];
            r_el    <= c_el[VW-1:0];
            r_eh    <= c_eh[VW-1:0];
            r_w1    <= c_w1[VW-1:0];
            r_w2    <= c_w2[VW-1:0];
        end
        if (r_state == ST_SIDE) begin
            if (r_zero || (s_scale && s_den <= 0)) begin
                r_mag_r   <= '0;
                r_mag_w   <= OUT_W'(1);
                r_divisor <= DIVISOR_W'(1);
                r_neg     <= 1'b0;
            end else if (s_scale) begin
                r_mag_r   <= s_rabs[OUT_W-1:0];
                r_mag_w   <= s_nabs[OUT_W-1:0];
                r_divisor <= s_den[DIVISOR_W-1:0];
                r_neg     <= s_rr[VW-1] ^ s_num[VW-1];
            end else begin
                r_mag_r   <= s_rabs[OUT_W-1:0];
                r_mag_w   <= OUT_W'(1);
                r_divisor <= DIVISOR_W'(1);
                r_neg     <= s_rr[VW-1];
            end
        end
        if (r_state == ST_DIV && div_done) begin
            r_result <= d_res;
        end
    end

    // product goes straight into the divider's dividend register
    jac_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DIVIDEND_W'(r_mag_r) * DIVIDEND_W'(r_mag_w)),
        .i_divisor  (r_divisor),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    a_held_only_in_hyst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_HYST) |=> $stable(r_held))
        else $error("held position changed outside the hysteresis step");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_beat_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> (r_state == ST_HYST))
        else $error("accepted beat did not start the sequence");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((r_result <= 16'sd20000) && (r_result >= -16'sd20000)))
        else $error("result outside the output limits");

endmodule

>>> tb/tb.sv
module tb;
    import jac_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 155;
    localparam int WIDE_MAX    = (1 << CFG_W) - 1;
    localparam int NARROW_MAX  = (1 << SMALL_W) - 1;
    localparam int RAW_MAX     = (1 << SAMPLE_BITS) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    jac_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    jac_out_if result_ch ();

    joystick_axis_calibrator #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (sample_ch),
        .o_result    (result_ch)
    );

    // calibration settings and hysteresis state as the block should hold them
    logic [CFG_W-1:0]       lim_low    = RANGE_LOW_RESET;
    logic [CFG_W-1:0]       lim_center = RANGE_CENTER_RESET;
    logic [CFG_W-1:0]       lim_high   = RANGE_HIGH_RESET;
    logic [SMALL_W-1:0]     dead_band  = '0;
    logic [SMALL_W-1:0]     rise_min   = '0;
    logic [SMALL_W-1:0]     fall_min   = '0;
    logic [SAMPLE_BITS-1:0] held_pos   = SAMPLE_BITS'(HELD_RESET);

    logic [SAMPLE_BITS-1:0]  raw_q[$];
    logic signed [OUT_W-1:0] calib_q[$];
    logic signed [OUT_W-1:0] want;
    int                      last_raw;
    int                      send_gap;
    int                      recv_stall;
    int                      quiet;
    int                      failures;
    bit                      no_idle;
    bit                      in_beat;
    bit                      out_beat;

    function automatic logic signed [OUT_W-1:0] calibrate_sample(
        logic [SAMPLE_BITS-1:0] raw);
        longint pos, hold, lo, hi, ctr, edge_lo, edge_hi, span_lo, span_hi, r;
        pos  = longint'(raw);
        hold = longint'(held_pos);
        lo   = longint'(lim_low);
        hi   = longint'(lim_high);
        ctr  = longint'(lim_center);
        if (pos > hold) begin
            if (pos > hold + longint'(rise_min)) hold = pos;
            else pos = hold;
        end else if (pos < hold - longint'(fall_min)) begin
            hold = pos;
        end else begin
            pos = hold;
        end
        held_pos = hold[SAMPLE_BITS-1:0];
        edge_lo  = ctr - longint'(dead_band);
        edge_hi  = ctr + longint'(dead_band);
        if (pos >= edge_lo && pos <= edge_hi) begin
            r = 0;
        end else begin
            if (pos < lo) pos = lo;
            else if (pos > hi) pos = hi;
            span_lo = edge_lo - lo;
            span_hi = hi - edge_hi;
            if (pos < ctr) begin
                r = pos - edge_lo;
                if (span_lo > span_hi) r = (span_lo <= 0) ? 0 : r * span_hi / span_lo;
            end else begin
                r = pos - edge_hi;
                if (span_hi > span_lo) r = (span_hi <= 0) ? 0 : r * span_lo / span_hi;
            end
        end
        if (r > OUT_LIMIT) r = OUT_LIMIT;
        else if (r < -OUT_LIMIT) r = -OUT_LIMIT;
        return r[OUT_W-1:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_RANGE_LOW:    lim_low    = data;
            CFG_RANGE_CENTER: lim_center = data;
            CFG_RANGE_HIGH:   lim_high   = data;
            CFG_DEAD_ZONE:    dead_band  = data[SMALL_W-1:0];
            CFG_JITTER_UP:    rise_min   = data[SMALL_W-1:0];
            CFG_JITTER_DOWN:  fall_min   = data[SMALL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(int lo, int ctr, int hi, int dz, int up, int down);
        write_reg(CFG_RANGE_LOW, CFG_W'(lo));
        write_reg(CFG_RANGE_CENTER, CFG_W'(ctr));
        write_reg(CFG_RANGE_HIGH, CFG_W'(hi));
        write_reg(CFG_DEAD_ZONE, CFG_W'(dz));
        write_reg(CFG_JITTER_UP, CFG_W'(up));
        write_reg(CFG_JITTER_DOWN, CFG_W'(down));
        @(negedge i_clk);
    endtask

    task automatic push_raw(int v);
        raw_q.push_back(SAMPLE_BITS'(v));
    endtask

    function automatic int pick_wide();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return WIDE_MAX;
            2:       return $urandom_range(0, WIDE_MAX);
            default: return $urandom_range(0, 20000);
        endcase
    endfunction

    // junk above the register width must be dropped by the block
    function automatic int pick_narrow(int style);
        int v;
        if (style == 0) return 0;
        if (style == 1) return WIDE_MAX;
        case ($urandom_range(0, 4))
            0:       v = 0;
            1:       v = NARROW_MAX;
            2:       v = $urandom_range(0, 16);
            default: v = $urandom_range(0, NARROW_MAX);
        endcase
        return v | ($urandom_range(0, 1) ? ($urandom_range(0, 127) << SMALL_W) : 0);
    endfunction

    task automatic random_setup(int style);
        int lo, ctr, hi;
        if (style == 0) begin
            lo = 0;
            ctr = 0;
            hi = 0;
        end else if (style == 1) begin
            lo = WIDE_MAX;
            ctr = WIDE_MAX;
            hi = WIDE_MAX;
        end else if ($urandom_range(0, 9) < 6) begin
            lo  = $urandom_range(0, 9000);
            ctr = lo + $urandom_range(0, 11000);
            hi  = ctr + $urandom_range(0, 12000);
        end else begin
            lo  = pick_wide();
            ctr = pick_wide();
            hi  = pick_wide();
        end
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      CFG_W'($urandom));
        setup(lo, ctr, hi, pick_narrow(style), pick_narrow(style), pick_narrow(style));
    endtask

    // samples mostly around the centre band, the previous sample and the limits
    function automatic logic [SAMPLE_BITS-1:0] next_raw();
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom_range(0, RAW_MAX);
            2, 3: v = int'(lim_center) - int'(dead_band) - 4
                      + int'($urandom_range(0, 2 * dead_band + 8));
            4, 5: v = last_raw - int'(fall_min) - 4
                      + int'($urandom_range(0, rise_min + fall_min + 8));
            6:    v = $urandom_range(lim_high, lim_low);
            7: begin
                case ($urandom_range(0, 6))
                    0:       v = 0;
                    1:       v = RAW_MAX;
                    2:       v = WIDE_MAX;
                    3:       v = WIDE_MAX + 1;
                    4:       v = lim_low;
                    5:       v = lim_high;
                    default: v = lim_center;
                endcase
            end
            default: v = $urandom_range(0, WIDE_MAX);
        endcase
        if (v < 0) v = 0;
        if (v > RAW_MAX) v = RAW_MAX;
        last_raw = v;
        return SAMPLE_BITS'(v);
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (raw_q.size() != 0 || sample_ch.valid || calib_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        int phase, n;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = '0;
        i_cfg_data             = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.raw_position = '0;
        result_ch.ready        = 1'b0;
        failures               = 0;
        send_gap               = 0;
        recv_stall             = 0;
        quiet                  = 0;
        no_idle                = 1'b0;
        last_raw               = HELD_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults after reset, starting from the held position
        push_raw(200); push_raw(199); push_raw(201); push_raw(0);
        push_raw(RAW_MAX); push_raw(10000); push_raw(20000); push_raw(20001);
        wait_drained();

        // widest dead band and hysteresis, upper data bits set
        setup(1000, 5000, 30000, 15'h7FFF, 15'h5AFF, 15'h00FF);
        push_raw(5000); push_raw(5255); push_raw(4745); push_raw(5256);
        push_raw(5100); push_raw(4000); push_raw(4100); push_raw(0);
        push_raw(RAW_MAX);
        wait_drained();

        // inverted limits, where negative widths block the scaling
        write_reg(CFG_SPARE_LO, CFG_W'(1234));
        write_reg(CFG_SPARE_HI, CFG_W'(WIDE_MAX));
        setup(20000, 10000, 1000, 0, 0, 0);
        push_raw(500); push_raw(10000); push_raw(RAW_MAX);
        wait_drained();

        // inverted limits leave the top open, so the output saturates
        setup(1000, 20000, 0, 0, 0, 0);
        push_raw(RAW_MAX); push_raw(30000); push_raw(0); push_raw(19999);
        wait_drained();

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            random_setup(phase < 2 ? phase : 2);
            no_idle = (phase % 4 == 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && phase % 3 == 0) wait_drained();
                raw_q.push_back(next_raw());
            end
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (failures == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    // sample driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_beat = sample_ch.valid && sample_ch.ready;
            if (in_beat) begin
                calib_q.push_back(calibrate_sample(sample_ch.raw_position));
                send_gap = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (!sample_ch.valid || in_beat) begin
                if (send_gap > 0) begin
                    send_gap--;
                    sample_ch.valid <= 1'b0;
                end else if (raw_q.size() != 0) begin
                    sample_ch.valid        <= 1'b1;
                    sample_ch.raw_position <= raw_q.pop_front();
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            out_beat = result_ch.valid && result_ch.ready;
            if (out_beat) begin
                if (calib_q.size() == 0) begin
                    failures++;
                    $error("calibrated_position: expected none, got %0d",
                           result_ch.calibrated_position);
                end else begin
                    want = calib_q.pop_front();
                    if (result_ch.calibrated_position !== want) begin
                        failures++;
                        $error("calibrated_position: expected %0d, got %0d",
                               want, result_ch.calibrated_position);
                    end
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (recv_stall > 0) begin
                result_ch.ready <= 1'b0;
                if (result_ch.valid) recv_stall--;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
